// ===== rtl/core/dep_pkg.sv =====
// shared types, sizes and codes for the double-ended priority queue
// used by every module of the block; depends on nothing else
package dep_pkg;

   localparam int CAPACITY     = 256;
   localparam int KEY_BITS     = 24;
   localparam int PAYLOAD_BITS = 24;

   // fixed widths of the request and response fields
   localparam int CMD_FIELD_BITS = 2;
   localparam int KEY_FIELD_BITS = 24;
   localparam int PAY_FIELD_BITS = 24;
   localparam int STS_FIELD_BITS = 2;

   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int FAN_IN     = 8;
   // one flag bit for a matching key plus the payload of the top entry
   localparam int TREE_BITS  = PAYLOAD_BITS + 1;

   typedef enum logic [CMD_FIELD_BITS-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_POP_MAX = 2'd1,
      CMD_POP_MIN = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [STS_FIELD_BITS-1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2,
      STS_DUP   = 2'd3
   } status_type;

   typedef struct packed {
      logic [CMD_FIELD_BITS-1:0] command;
      logic [KEY_FIELD_BITS-1:0] priority_req;
      logic [PAY_FIELD_BITS-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [PAY_FIELD_BITS-1:0] payload_out;
      logic [STS_FIELD_BITS-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic                    valid;
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } cell_data_type;

   typedef struct packed {
      logic                    find_dup;
      logic                    find_max;
      logic                    shift_ins;
      logic                    shift_min;
      logic                    drop_max;
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } cell_ctrl_type;

   // nodes in level lvl of the reduction tree, level 0 sits on the cells
   function automatic int level_nodes(input int lvl);
      int n;
      n = CAPACITY;
      for (int i = 0; i <= lvl; i++) begin
         n = (n + FAN_IN - 1) / FAN_IN;
      end
      return n;
   endfunction

   function automatic int tree_levels();
      int n;
      int lv;
      n  = CAPACITY;
      lv = 0;
      for (int i = 0; i < 32; i++) begin
         if (n > 1 || lv == 0) begin
            n  = (n + FAN_IN - 1) / FAN_IN;
            lv = lv + 1;
         end
      end
      return lv;
   endfunction

   localparam int TREE_LEVELS = tree_levels();
   localparam int WAIT_BITS   = $clog2(TREE_LEVELS + 1);

endpackage

// ===== rtl/core/dep_cell.sv =====
// one slot of the sorted array: holds a key, a payload and a valid bit
// depends on dep_pkg; trades entries with its two neighbors
module dep_cell import dep_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  cell_data_type        prev_data,
   input  logic                 prev_lt,
   input  cell_data_type        next_data,
   output cell_data_type        data,
   output logic                 lt,
   output logic [TREE_BITS-1:0] tree_bits
);

   cell_data_type data_ff;
   cell_data_type data_in;
   logic          hit;
   logic          is_top;

   assign lt     = data_ff.valid && (data_ff.key < ctrl.key);
   assign hit    = data_ff.valid && (data_ff.key == ctrl.key);
   assign is_top = data_ff.valid && !next_data.valid;
   assign data   = data_ff;

   assign tree_bits = {(ctrl.find_max && is_top) ? data_ff.payload : {PAYLOAD_BITS{1'b0}},
                       ctrl.find_dup && hit};

   always_comb begin
      data_in = data_ff;
      priority if (ctrl.shift_ins) begin
         // smaller keys stay, the first larger slot takes the new entry
         if (lt) begin
            data_in = data_ff;
         end else if (prev_lt) begin
            data_in.valid   = 1'b1;
            data_in.key     = ctrl.key;
            data_in.payload = ctrl.payload;
         end else begin
            data_in = prev_data;
         end
      end else if (ctrl.shift_min) begin
         data_in = next_data;
      end else if (ctrl.drop_max && is_top) begin
         data_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/core/dep_or_tree.sv =====
// registered or-reduction over the flags and payloads of all cells
// depends on dep_pkg; each level registers one node per group of FAN_IN inputs
module dep_or_tree import dep_pkg::*; (
   input  logic                 clock,
   input  logic [TREE_BITS-1:0] leaf [CAPACITY],
   output logic [TREE_BITS-1:0] root
);

   logic [TREE_BITS-1:0] node_ff [TREE_LEVELS][CAPACITY];
   logic [TREE_BITS-1:0] node_in [TREE_LEVELS][CAPACITY];

   for (genvar l = 0; l < TREE_LEVELS; l++) begin : g_level
      localparam int PREV = (l == 0) ? CAPACITY : level_nodes(l - 1);
      for (genvar j = 0; j < level_nodes(l); j++) begin : g_node
         localparam int FAN = ((PREV - j * FAN_IN) < FAN_IN) ? (PREV - j * FAN_IN) : FAN_IN;
         if (l == 0) begin : g_leaf
            always_comb begin
               node_in[l][j] = '0;
               for (int k = 0; k < FAN; k++) begin
                  node_in[l][j] = node_in[l][j] | leaf[j * FAN_IN + k];
               end
            end
         end else begin : g_inner
            always_comb begin
               node_in[l][j] = '0;
               for (int k = 0; k < FAN; k++) begin
                  node_in[l][j] = node_in[l][j] | node_ff[l - 1][j * FAN_IN + k];
               end
            end
         end
         always_ff @(posedge clock) begin
            node_ff[l][j] <= node_in[l][j];
         end
      end
   end

   assign root = node_ff[TREE_LEVELS - 1][0];

endmodule

// ===== rtl/core/double_ended_priority_queue_unit.sv =====
// double-ended priority queue built as a sorted row of cells
// depends on dep_pkg, dep_cell and dep_or_tree
// Usage:
//   req_data carries a command, a priority and a payload. Insert places the
//   pair in key order (a key already present is left alone and reported as a
//   duplicate, a new key into a full queue is dropped); pop-max and pop-min
//   take the largest or smallest entry out and return its payload.
//   Every request gives exactly one response on rsp_data (payload, status).
//   A request is taken when req_valid is high and req_stall low; the
//   response is taken when rsp_valid is high and rsp_stall low.
// Timing:
//   One request at a time. The cells are searched through a registered
//   or-tree of TREE_LEVELS levels (3 for 256 entries); once the result
//   reaches the root the cells update and the response is registered, and
//   the unit goes back to idle to take the next request.
//   A finished response waits in its output register while the next request
//   is accepted; while rsp_stall holds an undelivered response, the next
//   request is held just before it changes the cells.
// Reset: synchronous reset empties the queue at once and drops pending work.
module double_ended_priority_queue_unit import dep_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WAIT,
      S_APPLY
   } state_type;

   state_type               state_ff;
   logic [WAIT_BITS-1:0]    wait_ff;
   logic [COUNT_BITS-1:0]   count_ff;
   logic [COUNT_BITS-1:0]   count_in;
   cmd_type                 cmd_ff;
   logic [KEY_BITS-1:0]     key_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;

   cell_ctrl_type           ctrl;
   cell_data_type           cell_data [CAPACITY];
   cell_data_type           prev_data [CAPACITY];
   cell_data_type           next_data [CAPACITY];
   logic                    cell_lt   [CAPACITY];
   logic                    prev_lt   [CAPACITY];
   logic [TREE_BITS-1:0]    leaf      [CAPACITY];
   logic [TREE_BITS-1:0]    root;

   logic                    apply_en;
   logic                    is_full;
   logic                    is_empty;
   logic                    dup_found;
   logic                    insert_ok;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // hold the update while an older response still waits to be taken
   assign apply_en  = (state_ff == S_APPLY) && !(rsp_valid_ff && rsp_stall);
   assign is_full   = (count_ff == COUNT_BITS'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign dup_found = root[0];
   assign insert_ok = (cmd_ff == CMD_INSERT) && !dup_found && !is_full;

   always_comb begin
      ctrl.find_dup  = (cmd_ff == CMD_INSERT);
      ctrl.find_max  = (cmd_ff == CMD_POP_MAX);
      ctrl.shift_ins = apply_en && insert_ok;
      ctrl.shift_min = apply_en && (cmd_ff == CMD_POP_MIN) && !is_empty;
      ctrl.drop_max  = apply_en && (cmd_ff == CMD_POP_MAX) && !is_empty;
      ctrl.key       = key_ff;
      ctrl.payload   = pay_ff;
   end

   always_comb begin
      rsp_in.payload_out = '0;
      rsp_in.status      = STS_OK;
      count_in           = count_ff;
      unique case (cmd_ff)
         CMD_INSERT: begin
            if (dup_found) begin
               rsp_in.status = STS_DUP;
            end else if (is_full) begin
               rsp_in.status = STS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_MAX: begin
            if (is_empty) begin
               rsp_in.status = STS_EMPTY;
            end else begin
               count_in           = count_ff - 1'b1;
               rsp_in.payload_out = PAY_FIELD_BITS'(root[PAYLOAD_BITS:1]);
            end
         end
         CMD_POP_MIN: begin
            if (is_empty) begin
               rsp_in.status = STS_EMPTY;
            end else begin
               count_in           = count_ff - 1'b1;
               rsp_in.payload_out = PAY_FIELD_BITS'(cell_data[0].payload);
            end
         end
         CMD_NOP: begin
            rsp_in.status = STS_OK;
         end
         default: begin
            rsp_in.status = STS_OK;
         end
      endcase
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prev_data[i] = '0;
         assign prev_lt[i]   = 1'b1;
      end else begin : g_mid
         assign prev_data[i] = cell_data[i - 1];
         assign prev_lt[i]   = cell_lt[i - 1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_data[i] = '0;
      end else begin : g_inner
         assign next_data[i] = cell_data[i + 1];
      end

      dep_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .prev_data (prev_data[i]),
         .prev_lt   (prev_lt[i]),
         .next_data (next_data[i]),
         .data      (cell_data[i]),
         .lt        (cell_lt[i]),
         .tree_bits (leaf[i])
      );
   end

   dep_or_tree u_tree (
      .clock (clock),
      .leaf  (leaf),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wait_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new response may replace one taken at this same edge
         if (apply_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= cmd_type'(req_data.command);
                  key_ff   <= req_data.priority_req[KEY_BITS-1:0];
                  pay_ff   <= req_data.payload[PAYLOAD_BITS-1:0];
                  wait_ff  <= '0;
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               // let the search ripple up every tree level
               if (wait_ff == WAIT_BITS'(TREE_LEVELS - 1)) begin
                  state_ff <= S_APPLY;
               end else begin
                  wait_ff <= wait_ff + 1'b1;
               end
            end
            S_APPLY: begin
               if (apply_en) begin
                  rsp_ff   <= rsp_in;
                  count_ff <= count_in;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== tb/sv/double_ended_priority_queue_unit_test.sv =====
// self-checking testbench for double_ended_priority_queue_unit
// depends on dep_pkg and the queue rtl; the expected responses come from a sorted list kept here
`timescale 1ns / 100ps

module double_ended_priority_queue_unit_test;
   import dep_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 4 * (TREE_LEVELS + 2);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type cmd_backlog[$];
   rsp_type due_responses[$];
   logic [KEY_BITS-1:0]     sorted_keys[$];
   logic [PAYLOAD_BITS-1:0] sorted_pays[$];
   logic [KEY_FIELD_BITS-1:0] key_pool[32];

   int          mismatch_count = 0;
   int          accepted_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          offer_held = 1'b0;
   bit          req_taken = 1'b0;
   bit          long_hold = 1'b0;

   double_ended_priority_queue_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   // applies one request to the sorted list and returns the response it should give
   function automatic rsp_type apply_command(input req_type r);
      rsp_type                 o;
      int                      pos;
      logic [KEY_BITS-1:0]     k;
      logic [PAYLOAD_BITS-1:0] v;
      o = '0;
      o.status = STS_OK;
      k = r.priority_req[KEY_BITS-1:0];
      v = r.payload[PAYLOAD_BITS-1:0];
      case (cmd_type'(r.command))
         CMD_INSERT: begin
            pos = 0;
            while (pos < sorted_keys.size() && sorted_keys[pos] < k) pos++;
            // duplicate wins over full
            if (pos < sorted_keys.size() && sorted_keys[pos] == k) begin
               o.status = STS_DUP;
            end else if (sorted_keys.size() >= CAPACITY) begin
               o.status = STS_FULL;
            end else begin
               sorted_keys.insert(pos, k);
               sorted_pays.insert(pos, v);
            end
         end
         CMD_POP_MAX: begin
            if (sorted_keys.size() == 0) begin
               o.status = STS_EMPTY;
            end else begin
               o.payload_out = sorted_pays.pop_back();
               void'(sorted_keys.pop_back());
            end
         end
         CMD_POP_MIN: begin
            if (sorted_keys.size() == 0) begin
               o.status = STS_EMPTY;
            end else begin
               o.payload_out = sorted_pays.pop_front();
               void'(sorted_keys.pop_front());
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   task automatic push_request(input cmd_type c, input logic [KEY_FIELD_BITS-1:0] k,
                               input logic [PAY_FIELD_BITS-1:0] p);
      req_type r;
      r.command      = c;
      r.priority_req = k;
      r.payload      = p;
      cmd_backlog.push_back(r);
   endtask

   function automatic logic [KEY_FIELD_BITS-1:0] rand_key();
      return KEY_FIELD_BITS'($urandom);
   endfunction

   function automatic logic [PAY_FIELD_BITS-1:0] rand_payload();
      return PAY_FIELD_BITS'($urandom);
   endfunction

   // two in five keys from the pool so duplicates and repeat hits happen, some extremes, rest full range
   function automatic logic [KEY_FIELD_BITS-1:0] pick_key();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return key_pool[$urandom_range(0, 31)];
      if (r < 44) return '0;
      if (r < 48) return '1;
      return rand_key();
   endfunction

   function automatic logic [PAY_FIELD_BITS-1:0] pick_payload();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      return rand_payload();
   endfunction

   task automatic push_mixed(input int n);
      int unsigned r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50) push_request(CMD_INSERT, pick_key(), pick_payload());
         else if (r < 73) push_request(CMD_POP_MAX, rand_key(), rand_payload());
         else if (r < 96) push_request(CMD_POP_MIN, rand_key(), rand_payload());
         else push_request(CMD_NOP, rand_key(), rand_payload());
      end
   endtask

   // fill past capacity, hit the full queue with new and present keys, then drain past empty
   task automatic push_fill_and_drain();
      logic [KEY_FIELD_BITS-1:0] fill_keys[$];
      logic [KEY_FIELD_BITS-1:0] k;
      for (int i = 0; i < CAPACITY + 14; i++) begin
         k = rand_key();
         fill_keys.push_back(k);
         push_request(CMD_INSERT, k, pick_payload());
      end
      for (int i = 0; i < 10; i++) begin
         if (i % 3 == 0) k = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
         else k = rand_key();
         push_request(CMD_INSERT, k, pick_payload());
      end
      for (int i = 0; i < CAPACITY + 24; i++) begin
         if ($urandom_range(0, 1) == 0) push_request(CMD_POP_MAX, rand_key(), rand_payload());
         else push_request(CMD_POP_MIN, rand_key(), rand_payload());
      end
   endtask

   task automatic wait_backlog_sent();
      while (cmd_backlog.size() != 0 || offer_held) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_taken) begin
            req_taken  = 1'b0;
            offer_held = 1'b0;
         end
         if (!offer_held) begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data   <= cmd_backlog.pop_front();
               req_valid  <= 1'b1;
               offer_held = 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall driver
   always @(negedge clock) begin
      rsp_stall <= long_hold || ($urandom_range(0, 99) < recv_stall_pct);
   end

   // request and response monitor
   always @(posedge clock) begin
      rsp_type exp;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            due_responses.push_back(apply_command(req_data));
            accepted_count++;
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_responses.size() == 0) begin
               report_mismatch($sformatf("unexpected response payload %h status %0d",
                                         rsp_data.payload_out, rsp_data.status));
            end else begin
               exp = due_responses.pop_front();
               if (rsp_data.payload_out !== exp.payload_out)
                  report_mismatch($sformatf("payload_out %h, expected %h",
                                            rsp_data.payload_out, exp.payload_out));
               if (rsp_data.status !== exp.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, exp.status));
            end
         end
      end
   end

   // long receiver hold-off while requests keep coming, so the input backs up
   initial begin
      wait (accepted_count >= 40);
      @(posedge clock);
      long_hold = 1'b1;
      repeat (300) @(posedge clock);
      long_hold = 1'b0;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      for (int i = 0; i < 32; i++) key_pool[i] = rand_key();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pops, unused command, extreme keys and payloads, duplicates
      push_request(CMD_POP_MAX, '1, '1);
      push_request(CMD_POP_MIN, '0, '0);
      push_request(CMD_NOP, '1, '1);
      push_request(CMD_INSERT, 24'h000000, 24'hffffff);
      push_request(CMD_INSERT, 24'hffffff, 24'h000000);
      push_request(CMD_INSERT, 24'h800000, 24'h5a5a5a);
      push_request(CMD_INSERT, 24'h000000, 24'h123456);
      push_request(CMD_INSERT, 24'hffffff, 24'h654321);
      push_request(CMD_POP_MAX, '0, '0);
      push_request(CMD_POP_MIN, '1, '1);
      push_request(CMD_POP_MIN, 24'h123456, 24'h654321);
      push_request(CMD_POP_MIN, '0, '0);
      push_request(CMD_INSERT, 24'h555555, 24'haaaaaa);
      push_request(CMD_INSERT, 24'haaaaaa, 24'h555555);
      push_request(CMD_NOP, '0, '0);
      push_request(CMD_POP_MAX, 24'h555555, 24'hffffff);
      push_request(CMD_POP_MAX, '1, '0);
      push_request(CMD_POP_MAX, '0, '1);
      push_request(CMD_INSERT, 24'h7fffff, 24'h800000);
      push_request(CMD_INSERT, 24'h800000, 24'h7fffff);
      push_request(CMD_POP_MIN, '0, '0);
      push_request(CMD_POP_MIN, '0, '0);

      // no idling, long hold-off lands here
      push_mixed(330);
      wait_backlog_sent();

      send_idle_pct = 67;
      push_mixed(330);
      wait_backlog_sent();

      send_idle_pct  = 0;
      recv_stall_pct = 67;
      push_fill_and_drain();
      push_mixed(90);
      wait_backlog_sent();

      send_idle_pct  = 38;
      recv_stall_pct = 38;
      push_mixed(330);
      wait_backlog_sent();

      recv_stall_pct = 0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (due_responses.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", due_responses.size()));

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
